### src/dwt_pkg.sv
// ----------------------------------------------------------------------------
// dwt_pkg: shared constants of the distance window trend detector
// Holds the default sizes of the sample window and the trend test threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dwt_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 10;
    localparam int DEFAULT_SAMPLE_BITS  = 16;
    localparam int DEFAULT_COUNT_BITS   = $clog2(DEFAULT_WINDOW_DEPTH + 1);

    // The trend test needs more than this many entries in the window.
    localparam int TREND_MIN_COUNT = 2;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_READ   = 1'b1
    } t_action;

endpackage

`default_nettype wire

### src/dwt_if.sv
// ----------------------------------------------------------------------------
// dwt_if: transaction channels of the distance window trend detector
// The item channel carries a sample or a host read; the result channel
// carries the latest distance, the flags and the window fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dwt_item_if #(
    parameter int SAMPLE_BITS = dwt_pkg::DEFAULT_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [SAMPLE_BITS-1:0] sample_mm;

    modport source (output valid, output action, output sample_mm, input ready);
    modport sink   (input valid, input action, input sample_mm, output ready);
endinterface

interface dwt_result_if #(
    parameter int SAMPLE_BITS = dwt_pkg::DEFAULT_SAMPLE_BITS,
    parameter int COUNT_BITS  = dwt_pkg::DEFAULT_COUNT_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_BITS:0] latest_mm;
    logic                        accepted;
    logic                        new_meas;
    logic                        not_decreasing;
    logic [COUNT_BITS-1:0]       fill_count;

    modport source (output valid, output latest_mm, output accepted, output new_meas,
                    output not_decreasing, output fill_count, input ready);
    modport sink   (input valid, input latest_mm, input accepted, input new_meas,
                    input not_decreasing, input fill_count, output ready);
endinterface

`default_nettype wire

### src/dwt_core.sv
// ----------------------------------------------------------------------------
// dwt_core: sample window, running sum and trend test
// Keeps the accepted samples in a shift line with the newest at the head,
// maintains the running sum and the fresh flag, and presents the result
// fields of the current transaction as seen after its state update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dwt_core #(
    parameter int WINDOW_DEPTH = dwt_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = dwt_pkg::DEFAULT_SAMPLE_BITS,
    parameter int COUNT_BITS   = $clog2(WINDOW_DEPTH + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic                        i_action,
    input  wire logic [SAMPLE_BITS-1:0]      i_sample,
    output logic signed [SAMPLE_BITS:0]      o_latest,
    output logic                             o_accepted,
    output logic                             o_fresh,
    output logic                             o_rising,
    output logic [COUNT_BITS-1:0]            o_count
);

    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;

    logic [SAMPLE_BITS-1:0] r_store [WINDOW_DEPTH];
    logic [COUNT_BITS-1:0]  r_count;
    logic [SUM_BITS-1:0]    r_sum;
    logic                   r_fresh;

    logic                   full;
    logic                   take;
    logic [COUNT_BITS-1:0]  n_count;
    logic [SUM_BITS-1:0]    n_sum;
    logic [SAMPLE_BITS-1:0] n_newest;
    logic                   n_fresh;
    logic [SUM_BITS-1:0]    leaving;
    logic [SUM_BITS-1:0]    product;

    always_comb begin
        full    = (r_count == COUNT_BITS'(WINDOW_DEPTH));
        take    = i_step && (i_action == dwt_pkg::ACT_SAMPLE)
                  && ((r_count == '0) || (i_sample != r_store[0]));
        leaving = full ? SUM_BITS'(r_store[WINDOW_DEPTH-1]) : '0;

        n_count  = r_count;
        n_sum    = r_sum;
        n_newest = r_store[0];
        n_fresh  = r_fresh;
        if (take) begin
            n_newest = i_sample;
            n_sum    = r_sum - leaving + SUM_BITS'(i_sample);
            n_fresh  = 1'b1;
            if (!full) begin
                n_count = r_count + 1'b1;
            end
        end else if (i_step && (i_action == dwt_pkg::ACT_READ)) begin
            n_fresh = 1'b0;
        end

        product    = SUM_BITS'(n_newest) * SUM_BITS'(n_count);
        o_latest   = (n_count == '0) ? '1 : $signed({1'b0, n_newest});
        o_accepted = take;
        o_fresh    = n_fresh;
        o_rising   = (n_count > COUNT_BITS'(dwt_pkg::TREND_MIN_COUNT)) && (product >= n_sum);
        o_count    = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_fresh <= 1'b0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_fresh <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_store[0] <= i_sample;
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
                r_store[i] <= r_store[i-1];
            end
        end
    end

endmodule

`default_nettype wire

### src/distance_window_trend_top.sv
// ----------------------------------------------------------------------------
// distance_window_trend_top: moving-average trend detector over distances
// Each transaction on the item channel is a distance sample or a host read,
// and gives exactly one result transaction. The block accepts a new item in
// every cycle while the result side keeps taking results; an accepted item
// passes through the input register and then the result register before
// its result appears. The window is a shift line of accepted samples with a
// running sum, so the trend test is one multiply by the fill count and one
// compare, done combinationally between the two registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module distance_window_trend_top #(
    parameter int WINDOW_DEPTH = dwt_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = dwt_pkg::DEFAULT_SAMPLE_BITS,
    parameter int COUNT_BITS   = $clog2(WINDOW_DEPTH + 1)
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dwt_item_if.sink     i_item,
    dwt_result_if.source o_result
);

    logic                        r_in_valid;
    logic                        r_in_action;
    logic [SAMPLE_BITS-1:0]      r_in_sample;

    logic                        r_out_valid;
    logic signed [SAMPLE_BITS:0] r_out_latest;
    logic                        r_out_accepted;
    logic                        r_out_fresh;
    logic                        r_out_rising;
    logic [COUNT_BITS-1:0]       r_out_count;

    logic                        advance;
    logic                        in_ready;
    logic signed [SAMPLE_BITS:0] core_latest;
    logic                        core_accepted;
    logic                        core_fresh;
    logic                        core_rising;
    logic [COUNT_BITS-1:0]       core_count;

    assign advance  = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_item.ready            = in_ready;
    assign o_result.valid          = r_out_valid;
    assign o_result.latest_mm      = r_out_latest;
    assign o_result.accepted       = r_out_accepted;
    assign o_result.new_meas       = r_out_fresh;
    assign o_result.not_decreasing = r_out_rising;
    assign o_result.fill_count     = r_out_count;

    dwt_core #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_action   (r_in_action),
        .i_sample   (r_in_sample),
        .o_latest   (core_latest),
        .o_accepted (core_accepted),
        .o_fresh    (core_fresh),
        .o_rising   (core_rising),
        .o_count    (core_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.valid && in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && in_ready) begin
            r_in_action <= i_item.action;
            r_in_sample <= i_item.sample_mm;
        end
        if (advance) begin
            r_out_latest   <= core_latest;
            r_out_accepted <= core_accepted;
            r_out_fresh    <= core_fresh;
            r_out_rising   <= core_rising;
            r_out_count    <= core_count;
        end
    end

endmodule

`default_nettype wire
